/* rtl/core/cdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Ring depth, index widths, command and status codes, and ring index helpers.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH    = 256;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int FILL_W   = 8;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;
  localparam int CALC_W   = IDX_W + FILL_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5,
    CMD_ROTATE     = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam idx_t LAST_IDX = IDX_W'(DEPTH - 1);

  function automatic idx_t ring_next(input idx_t i);
    return (i == LAST_IDX) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t ring_prev(input idx_t i);
    return (i == '0) ? LAST_IDX : i - idx_t'(1);
  endfunction

  function automatic fill_t ring_count(input idx_t f, input idx_t r);
    logic [CALC_W-1:0] n;
    if (r >= f) begin
      n = CALC_W'(r) - CALC_W'(f);
    end else begin
      n = CALC_W'(r) + CALC_W'(DEPTH) - CALC_W'(f);
    end
    if (n > CALC_W'(255)) begin
      n = CALC_W'(255);
    end
    return n[FILL_W-1:0];
  endfunction

endpackage

/* rtl/core/cdq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/circular_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit elements in a ring
// Push, pop and peek at either end, and rotation of the front element to the
// rear, with full and empty reporting and the fill count after each command.
// ----------------------------------------------------------------------------
// For each command transfer the ring memory is read in the cycle of the
// transfer, and its registered read data is returned, together with the
// status and fill count, through the output register once the output side
// can take it; no new command is taken until then. A new command is taken
// while an earlier result still waits in the output register; the block
// holds at most DEPTH-1 elements and refuses pushes when full and reads
// when empty, leaving its state unchanged.
module circular_deque (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // cmd [2:0], push_value [34:3], zero padding [39:35]
  input  logic [cdq_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // read_value [31:0], status [33:32], fill_count [41:34], zero padding [47:42]
  output logic [cdq_pkg::OUT_W-1:0]  out_tdata
);

  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RD   = 2'b10
  } state_t;

  state_t  state_r, state_nxt;
  idx_t    front_r, front_nxt;
  idx_t    rear_r, rear_nxt;
  idx_t    rot_addr_r, rot_addr_nxt;
  logic    rot_pend_r, rot_pend_nxt;
  logic    use_rd_r, use_rd_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  cmd_t    cmd;
  word_t   push_value;
  logic    accept;
  logic    out_free;
  logic    none_held;
  logic    is_full;
  logic    ram_we;
  idx_t    ram_waddr;
  word_t   ram_wdata;
  logic    ram_re;
  idx_t    ram_raddr;
  word_t   ram_rdata;
  word_t   read_value;

  assign cmd        = cmd_t'(in_tdata[CMD_W-1:0]);
  assign push_value = in_tdata[CMD_W +: DATA_W];
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign none_held  = (front_r == rear_r);
  assign is_full    = (ring_next(rear_r) == front_r);
  assign read_value = use_rd_r ? ram_rdata : '0;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    rot_addr_nxt  = rot_addr_r;
    rot_pend_nxt  = rot_pend_r;
    use_rd_nxt    = use_rd_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = front_r;
    ram_wdata     = push_value;
    ram_re        = 1'b0;
    ram_raddr     = front_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_RD;
          rot_pend_nxt = 1'b0;
          use_rd_nxt   = 1'b0;
          status_nxt   = ST_OK;
          unique case (cmd)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_r;
                front_nxt = ring_prev(front_r);
              end
            end
            CMD_PUSH_REAR: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_next(rear_r);
                rear_nxt  = ring_next(rear_r);
              end
            end
            CMD_POP_FRONT: begin
              if (none_held) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = ring_next(front_r);
                use_rd_nxt = 1'b1;
                front_nxt  = ring_next(front_r);
              end
            end
            CMD_POP_REAR: begin
              if (none_held) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = rear_r;
                use_rd_nxt = 1'b1;
                rear_nxt   = ring_prev(rear_r);
              end
            end
            CMD_PEEK_FRONT: begin
              if (none_held) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = ring_next(front_r);
                use_rd_nxt = 1'b1;
              end
            end
            CMD_PEEK_REAR: begin
              if (none_held) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = rear_r;
                use_rd_nxt = 1'b1;
              end
            end
            CMD_ROTATE: begin
              if (none_held) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = ring_next(front_r);
                use_rd_nxt   = 1'b1;
                front_nxt    = ring_next(front_r);
                rear_nxt     = ring_next(rear_r);
                rot_addr_nxt = ring_next(rear_r);
                rot_pend_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          rot_pend_nxt  = 1'b0;
          ram_we        = rot_pend_r;
          ram_waddr     = rot_addr_r;
          ram_wdata     = ram_rdata;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_W - DATA_W - STAT_W - FILL_W)'(0),
                           ring_count(front_r, rear_r), status_r, read_value};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      rot_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      rot_pend_r  <= rot_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_addr_r <= rot_addr_nxt;
    use_rd_r   <= use_rd_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  cdq_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* tb/circular_deque_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_test: self-checking testbench for the circular deque
// Commands are streamed into the deque with random gaps, while the result
// side stalls at random. Each accepted command is run through a behavioural
// copy of the ring, and every returned element, status and fill count is
// compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module circular_deque_test;
  import cdq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    word_t   value;
    status_t status;
    fill_t   fill;
  } deque_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  word_t ring_copy [DEPTH];
  idx_t  front_slot = '0;
  idx_t  rear_slot = '0;

  deque_result_t expected_results[$];
  deque_result_t due;
  deque_result_t seen;
  int            fail_count = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  int            stall_pct = 10;
  int            gap_pct = 10;
  bit            calm = 1'b0;

  circular_deque uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic idx_t step_up(input idx_t i);
    return (int'(i) == DEPTH - 1) ? idx_t'(0) : idx_t'(int'(i) + 1);
  endfunction

  function automatic idx_t step_down(input idx_t i);
    return (int'(i) == 0) ? idx_t'(DEPTH - 1) : idx_t'(int'(i) - 1);
  endfunction

  function automatic int held_count();
    return (int'(rear_slot) + DEPTH - int'(front_slot)) % DEPTH;
  endfunction

  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] code,
                                                  input word_t value);
    deque_result_t r;
    bit            none_held;
    bit            is_full;
    int            n;
    r.value  = '0;
    r.status = ST_OK;
    none_held = (front_slot == rear_slot);
    is_full  = (step_up(rear_slot) == front_slot);
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else if (code == CMD_PUSH_FRONT) begin
          ring_copy[front_slot] = value;
          front_slot = step_down(front_slot);
        end else begin
          rear_slot = step_up(rear_slot);
          ring_copy[rear_slot] = value;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR, CMD_ROTATE: begin
        if (none_held) begin
          r.status = ST_EMPTY;
        end else begin
          case (code)
            CMD_POP_FRONT: begin
              front_slot = step_up(front_slot);
              r.value = ring_copy[front_slot];
            end
            CMD_POP_REAR: begin
              r.value = ring_copy[rear_slot];
              rear_slot = step_down(rear_slot);
            end
            CMD_PEEK_FRONT: r.value = ring_copy[step_up(front_slot)];
            CMD_PEEK_REAR: r.value = ring_copy[rear_slot];
            default: begin
              front_slot = step_up(front_slot);
              r.value = ring_copy[front_slot];
              rear_slot = step_up(rear_slot);
              ring_copy[rear_slot] = r.value;
            end
          endcase
        end
      end
      default: ;
    endcase
    n = held_count();
    r.fill = (n > 255) ? fill_t'(255) : fill_t'(n);
    return r;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] code, input word_t value);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_W - CMD_W - DATA_W){1'b0}}, value, code};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_command(code, value));
  endtask

  task automatic send_random(input int push_pct);
    logic [CMD_W-1:0] code;
    int               k;
    if ($urandom_range(0, 99) < push_pct) begin
      code = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else begin
      k = $urandom_range(0, 40);
      case (k % 5)
        0: code = CMD_POP_FRONT;
        1: code = CMD_POP_REAR;
        2: code = CMD_PEEK_FRONT;
        3: code = CMD_PEEK_REAR;
        default: code = CMD_ROTATE;
      endcase
      if (k == 40) begin
        code = CMD_UNUSED;
      end
    end
    send_command(code, $urandom);
  endtask

  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_and_extremes();
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_POP_REAR, $urandom);
    send_command(CMD_PEEK_FRONT, $urandom);
    send_command(CMD_PEEK_REAR, $urandom);
    send_command(CMD_ROTATE, $urandom);
    send_command(CMD_UNUSED, $urandom);
    send_command(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PEEK_FRONT, $urandom);
    send_command(CMD_PEEK_REAR, $urandom);
    send_command(CMD_PUSH_REAR, 32'h0000_0000);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED, $urandom);
    send_command(CMD_ROTATE, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_POP_REAR, $urandom);
    send_command(CMD_PEEK_FRONT, $urandom);
    send_command(CMD_POP_REAR, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_PEEK_REAR, $urandom);
    wait_until_drained();
  endtask

  task automatic test_full_ring();
    while (held_count() < DEPTH - 1) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
    end
    send_command(CMD_PUSH_FRONT, $urandom);
    send_command(CMD_PUSH_REAR, $urandom);
    send_command(CMD_UNUSED, $urandom);
    repeat (10) send_command(CMD_ROTATE, $urandom);
    send_command(CMD_PEEK_FRONT, $urandom);
    send_command(CMD_PEEK_REAR, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_PUSH_REAR, $urandom);
    send_command(CMD_ROTATE, $urandom);
    send_command(CMD_PUSH_FRONT, $urandom);
    while (held_count() > 0) begin
      send_random(0);
    end
    send_command(CMD_POP_REAR, $urandom);
    send_command(CMD_ROTATE, $urandom);
  endtask

  task automatic test_random_mix();
    int push_bias [5] = '{85, 50, 15, 95, 35};
    int p;
    for (p = 0; p < 5; p++) begin
      gap_pct   = (p == 2) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 3) ? 0 : $urandom_range(5, 40);
      repeat (90) send_random(push_bias[p]);
    end
  endtask

  task automatic test_drained_pause();
    int k;
    for (k = 0; k < 3; k++) begin
      repeat (30) send_random(55);
      wait_until_drained();
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (200) send_random(50);
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.value  = out_tdata[DATA_W-1:0];
      seen.status = status_t'(out_tdata[DATA_W+STAT_W-1:DATA_W]);
      seen.fill   = out_tdata[DATA_W+STAT_W+FILL_W-1:DATA_W+STAT_W];
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("Unexpected result transfer: value %h status %0d fill %0d",
                   seen.value, seen.status, seen.fill);
        end
      end else begin
        due = expected_results.pop_front();
        if (seen.value !== due.value || seen.status !== due.status ||
            seen.fill !== due.fill) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("Mismatch: expected value %h status %0d fill %0d, got %h %0d %0d",
                     due.value, due.status, due.fill,
                     seen.value, seen.status, seen.fill);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_full_ring();
    test_random_mix();
    test_drained_pause();
    test_back_to_back();
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
